@@ rtl/core/tva_pkg.sv @@
// tva_pkg: shared constants for the touch voice allocator
// command codes, configuration register indexes and reset values
// no dependencies
package tva_pkg;

	localparam int VOICE_COUNT_DEF = 8;

	localparam int CMD_W   = 3;
	localparam int COORD_W = 12;
	localparam int FREQ_W  = 19;
	localparam int AMP_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD        = 3'd0,
		CMD_MOVE       = 3'd1,
		CMD_REMOVE     = 3'd2,
		CMD_REMOVE_ALL = 3'd3,
		CMD_TICK       = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH_MAX  = 3'd0,
		REG_HEIGHT_MAX = 3'd1,
		REG_FREQ_FLOOR = 3'd2,
		REG_FREQ_SPAN  = 3'd3,
		REG_AMP_FLOOR  = 3'd4,
		REG_AMP_SPAN   = 3'd5
	} cfg_reg_t;

	localparam logic [COORD_W-1:0] WIDTH_MAX_RST  = 12'd4095;
	localparam logic [COORD_W-1:0] HEIGHT_MAX_RST = 12'd4095;
	localparam logic [FREQ_W-1:0]  FREQ_FLOOR_RST = 19'd1600;
	localparam logic [FREQ_W-1:0]  FREQ_SPAN_RST  = 19'd16000;
	localparam logic [AMP_W-1:0]   AMP_FLOOR_RST  = 16'd0;
	localparam logic [AMP_W-1:0]   AMP_SPAN_RST   = 16'd65535;

endpackage

@@ rtl/core/touch_voice_allocator.sv @@
// touch_voice_allocator: voice table with add, move, remove, remove-all and tick
// commands, frequency and amplitude mapping through a shared multiplier and divider
// depends on tva_pkg
//
// usage: pulse start with a command while busy is low; the beat is taken at that edge
// and busy stays high until the result. the result shows on the result ports for
// exactly one cycle with done high; the receiver cannot stall it, so it must take it.
// configuration is written through wr_en / wr_index / wr_data while idle, one
// register per cycle, no read-back.
// command flow (VOICE_COUNT = N):
//   remove-all, tick, undefined command: from the start beat straight to done
//   remove: a fetch and a match step per voice searched, at most N voices
//   add: voices scanned one per cycle for a free one, then the mapping, then done;
//     a full table skips the mapping
//   move: fetch and match per voice searched, then mapping; a failed search skips it
// one item at a time; the pace is set by the serial voice scan (one position
// memory read per voice) and the bit-serial divider: 19 steps for frequency and 16
// for amplitude, each after a multiply on the shared multiplier.
// reset clears all voice flags and loads the default configuration; position
// memory is not cleared since its contents are used only for voices that are on.
module touch_voice_allocator
	import tva_pkg::*;
#(
	parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [CMD_W-1:0]      command,
	input  logic [COORD_W-1:0]    touch_x,
	input  logic [COORD_W-1:0]    touch_y,
	input  logic [COORD_W-1:0]    prior_x,
	input  logic [COORD_W-1:0]    prior_y,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic                  done,
	output logic                  success,
	output logic [2:0]            voice_index,
	output logic                  params_valid,
	output logic [19:0]           frequency,
	output logic [16:0]           amp_target,
	output logic                  amp_from_zero,
	output logic                  all_off
);

	localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_COUNT - 1);
	localparam int POS_W = 2 * COORD_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FREE,
		S_FETCH,
		S_MATCH,
		S_MUL_F,
		S_DIV_F,
		S_MUL_A,
		S_DIV_A,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [COORD_W-1:0] width_max_q, height_max_q;
	logic [FREQ_W-1:0]  freq_floor_q, freq_span_q;
	logic [AMP_W-1:0]   amp_floor_q, amp_span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_max_q  <= WIDTH_MAX_RST;
			height_max_q <= HEIGHT_MAX_RST;
			freq_floor_q <= FREQ_FLOOR_RST;
			freq_span_q  <= FREQ_SPAN_RST;
			amp_floor_q  <= AMP_FLOOR_RST;
			amp_span_q   <= AMP_SPAN_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_WIDTH_MAX:  width_max_q  <= wr_data[COORD_W-1:0];
				REG_HEIGHT_MAX: height_max_q <= wr_data[COORD_W-1:0];
				REG_FREQ_FLOOR: freq_floor_q <= wr_data[FREQ_W-1:0];
				REG_FREQ_SPAN:  freq_span_q  <= wr_data[FREQ_W-1:0];
				REG_AMP_FLOOR:  amp_floor_q  <= wr_data[AMP_W-1:0];
				REG_AMP_SPAN:   amp_span_q   <= wr_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// latched command beat
	logic [CMD_W-1:0]   cmd_q;
	logic [COORD_W-1:0] tx_q, ty_q, px_q, py_q;

	// voice flags and search index
	logic [VOICE_COUNT-1:0] active_q, off_pend_q;
	logic [IDX_W-1:0]       scan_q;

	// shared multiply / divide datapath
	logic [COORD_W-1:0] div_d_q, rem_q;
	logic [FREQ_W-1:0]  dvd_q, quo_q;
	logic [4:0]         cnt_q;

	// result registers
	logic              success_q, pv_q, fz_q;
	logic [2:0]        idx_q;
	logic [19:0]       freq_q;
	logic [16:0]       amp_q;

	// position memory
	logic [POS_W-1:0] pos_mem [VOICE_COUNT];
	logic [POS_W-1:0] pos_rd_q;
	logic             mem_we;

	// full-scale values with zero treated as one, coordinates clamped
	logic [COORD_W-1:0] hgt, wid, yy, xx;
	assign hgt = (height_max_q == '0) ? COORD_W'(1) : height_max_q;
	assign wid = (width_max_q == '0) ? COORD_W'(1) : width_max_q;
	assign yy  = (ty_q > hgt) ? hgt : ty_q;
	assign xx  = (tx_q > wid) ? wid : tx_q;

	logic [FREQ_W-1:0]  mul_a;
	logic [COORD_W-1:0] mul_b;
	logic [30:0]        prod;
	assign mul_a = (state_q == S_MUL_F) ? freq_span_q : {3'b000, amp_span_q};
	assign mul_b = (state_q == S_MUL_F) ? (hgt - yy) : xx;
	assign prod  = 31'(mul_a) * 31'(mul_b);

	// restoring divider step
	logic [COORD_W:0]   trial, diff;
	logic               ge;
	logic [COORD_W-1:0] rem_nx;
	logic [FREQ_W-1:0]  quo_nx;
	assign trial  = {rem_q, dvd_q[FREQ_W-1]};
	assign ge     = trial >= {1'b0, div_d_q};
	assign diff   = trial - {1'b0, div_d_q};
	assign rem_nx = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
	assign quo_nx = {quo_q[FREQ_W-2:0], ge};

	// search compare
	logic [POS_W-1:0] key;
	logic             hit, free_hit, is_last;
	assign key      = (cmd_q == CMD_MOVE) ? {px_q, py_q} : {tx_q, ty_q};
	assign hit      = active_q[scan_q] && (pos_rd_q == key);
	assign free_hit = !active_q[scan_q];
	assign is_last  = (scan_q == LAST_IDX);

	assign mem_we = ((state_q == S_FREE) && free_hit) ||
	                ((state_q == S_MATCH) && hit && (cmd_q == CMD_MOVE));

	always_ff @(posedge clk) begin
		if (mem_we)
			pos_mem[scan_q] <= {tx_q, ty_q};
		pos_rd_q <= pos_mem[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= '0;
			off_pend_q <= '0;
			scan_q     <= '0;
			cmd_q      <= '0;
			tx_q       <= '0;
			ty_q       <= '0;
			px_q       <= '0;
			py_q       <= '0;
			div_d_q    <= '0;
			rem_q      <= '0;
			dvd_q      <= '0;
			quo_q      <= '0;
			cnt_q      <= '0;
			success_q  <= 1'b0;
			pv_q       <= 1'b0;
			fz_q       <= 1'b0;
			idx_q      <= '0;
			freq_q     <= '0;
			amp_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= command;
						tx_q      <= touch_x;
						ty_q      <= touch_y;
						px_q      <= prior_x;
						py_q      <= prior_y;
						scan_q    <= '0;
						success_q <= 1'b0;
						pv_q      <= 1'b0;
						fz_q      <= 1'b0;
						idx_q     <= '0;
						freq_q    <= '0;
						amp_q     <= '0;
						case (command)
							CMD_ADD:    state_q <= S_FREE;
							CMD_MOVE,
							CMD_REMOVE: state_q <= S_FETCH;
							CMD_REMOVE_ALL: begin
								off_pend_q <= off_pend_q | active_q;
								success_q  <= 1'b1;
								state_q    <= S_DONE;
							end
							CMD_TICK: begin
								active_q   <= active_q & ~off_pend_q;
								off_pend_q <= off_pend_q & ~active_q;
								success_q  <= 1'b1;
								state_q    <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FREE: begin
					if (free_hit) begin
						active_q[scan_q] <= 1'b1;
						idx_q     <= 3'(scan_q);
						success_q <= 1'b1;
						pv_q      <= 1'b1;
						fz_q      <= 1'b1;
						state_q   <= S_MUL_F;
					end else if (is_last) begin
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_FETCH: state_q <= S_MATCH;
				S_MATCH: begin
					if (hit) begin
						idx_q     <= 3'(scan_q);
						success_q <= 1'b1;
						if (cmd_q == CMD_MOVE) begin
							pv_q    <= 1'b1;
							state_q <= S_MUL_F;
						end else begin
							off_pend_q[scan_q] <= 1'b1;
							state_q <= S_DONE;
						end
					end else if (is_last) begin
						state_q <= S_DONE;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_MUL_F: begin
					// quotient fits 19 bits, so the top 12 product bits start below the divisor
					div_d_q <= hgt;
					rem_q   <= prod[30:19];
					dvd_q   <= prod[18:0];
					quo_q   <= '0;
					cnt_q   <= 5'd18;
					state_q <= S_DIV_F;
				end
				S_DIV_F: begin
					rem_q <= rem_nx;
					dvd_q <= {dvd_q[FREQ_W-2:0], 1'b0};
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						freq_q  <= {1'b0, freq_floor_q} + {1'b0, quo_nx};
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: begin
					div_d_q <= wid;
					rem_q   <= prod[27:16];
					dvd_q   <= {prod[15:0], 3'b000};
					quo_q   <= '0;
					cnt_q   <= 5'd15;
					state_q <= S_DIV_A;
				end
				S_DIV_A: begin
					rem_q <= rem_nx;
					dvd_q <= {dvd_q[FREQ_W-2:0], 1'b0};
					quo_q <= quo_nx;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						amp_q   <= {1'b0, amp_floor_q} + {1'b0, quo_nx[AMP_W-1:0]};
						state_q <= S_DONE;
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_DONE);
	assign success       = success_q;
	assign voice_index   = idx_q;
	assign params_valid  = pv_q;
	assign frequency     = freq_q;
	assign amp_target    = amp_q;
	assign amp_from_zero = fz_q;
	assign all_off       = ~|active_q;

endmodule
